// File: design/mwvs_pkg.sv
// mwvs_pkg: shared types and constants for the mass window vote scorer
// used by mwvs_ctrl, mwvs_dpath and the top level
`timescale 1ns / 1ps
package mwvs_pkg;

  // request codes
  localparam logic [2:0] REQ_LOAD_COL   = 3'd0;
  localparam logic [2:0] REQ_LOAD_ENTRY = 3'd1;
  localparam logic [2:0] REQ_CLEAR      = 3'd2;
  localparam logic [2:0] REQ_FRAG       = 3'd3;
  localparam logic [2:0] REQ_PREC       = 3'd4;
  localparam logic [2:0] REQ_READ       = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_COLUMN_COUNT    = 2'd0;
  localparam logic [1:0] CFG_MASS_SHIFT      = 2'd1;
  localparam logic [1:0] CFG_START_ITEM      = 2'd2;
  localparam logic [1:0] CFG_PRECURSOR_SCORE = 2'd3;

  localparam logic [14:0] SCORE_MAX = 15'h7FFF;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;     // latch the accepted item
    logic decode;      // loads and query window setup
    logic walk_start;  // take entry range bounds
    logic rmw;         // write raised score, advance entry
    logic skip_entry;  // advance entry without raise
    logic clear_init;  // restart clearing counter
    logic clear_step;  // write zero, advance counter
    logic finish;      // load output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [2:0] req;
    logic       skip;
    logic       walk_more;
    logic       row_ok;
    logic       clear_last;
    logic       out_busy;
  } stat_t;

endpackage

// File: design/mwvs_ctrl.sv
// mwvs_ctrl: request sequencer for the mass window vote scorer
// depends on mwvs_pkg
`timescale 1ns / 1ps
module mwvs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_xfer,
  output logic           idle,
  input  mwvs_pkg::stat_t st,
  output mwvs_pkg::cmd_t  cmd
);
  import mwvs_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECODE = 10'b0000000010,
    S_RANGE  = 10'b0000000100,
    S_LOAD   = 10'b0000001000,
    S_ENTRY  = 10'b0000010000,
    S_ROW    = 10'b0000100000,
    S_RMW    = 10'b0001000000,
    S_RDWAIT = 10'b0010000000,
    S_CLEAR  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   clr_reply, clr_reply_next;

  assign idle = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next     = state;
    clr_reply_next = clr_reply;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        case (st.req)
          REQ_CLEAR: begin
            cmd.clear_init = 1'b1;
            clr_reply_next = 1'b1;
            state_next     = S_CLEAR;
          end
          REQ_FRAG, REQ_PREC: state_next = st.skip ? S_DONE : S_RANGE;
          REQ_READ: state_next = S_RDWAIT;
          default: state_next = S_DONE;
        endcase
      end
      S_RANGE: state_next = S_LOAD;
      S_LOAD: begin
        cmd.walk_start = 1'b1;
        state_next     = S_ENTRY;
      end
      S_ENTRY: state_next = st.walk_more ? S_ROW : S_DONE;
      S_ROW: begin
        if (st.row_ok) begin
          state_next = S_RMW;
        end else begin
          cmd.skip_entry = 1'b1;
          state_next     = S_ENTRY;
        end
      end
      S_RMW: begin
        cmd.rmw    = 1'b1;
        state_next = S_ENTRY;
      end
      S_RDWAIT: state_next = S_DONE;
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_last) state_next = clr_reply ? S_DONE : S_IDLE;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register, reset runs the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_reply <= 1'b0;
    end else begin
      state     <= state_next;
      clr_reply <= clr_reply_next;
    end
  end

endmodule

// File: design/mwvs_dpath.sv
// mwvs_dpath: tables, score memory, window arithmetic and result register
// depends on mwvs_pkg
`timescale 1ns / 1ps
module mwvs_dpath #(
  parameter int COL_COUNT   = 1048576,
  parameter int ENTRY_COUNT = 1048576,
  parameter int ROW_COUNT   = 65536
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mwvs_pkg::cmd_t         cmd,
  output mwvs_pkg::stat_t        st,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [24:0]           cfg_data,
  input  logic [143:0]          in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [39:0]           out_data
);
  import mwvs_pkg::*;

  localparam int CAW = $clog2(COL_COUNT);
  localparam int EAW = $clog2(ENTRY_COUNT);
  localparam int RAW = $clog2(ROW_COUNT);
  localparam logic [24:0] COL_LIM   = 25'(COL_COUNT);
  localparam logic [24:0] ENTRY_LIM = 25'(ENTRY_COUNT);
  localparam logic [20:0] ROW_LIM   = 21'(ROW_COUNT);
  localparam logic [RAW-1:0] ROW_LAST = RAW'(ROW_COUNT - 1);

  // configuration registers
  logic [20:0]        column_count;
  logic signed [24:0] mass_shift;
  logic [15:0]        start_item;
  logic [14:0]        precursor_score;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= 21'h100000;
      mass_shift      <= '0;
      start_item      <= '0;
      precursor_score <= 15'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLUMN_COUNT:    column_count    <= cfg_data[20:0];
        CFG_MASS_SHIFT:      mass_shift      <= cfg_data;
        CFG_START_ITEM:      start_item      <= cfg_data[15:0];
        CFG_PRECURSOR_SCORE: precursor_score <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [2:0]         req;
  logic [19:0]        addr;
  logic [20:0]        rbeg, rend;
  logic [15:0]        rid;
  logic signed [24:0] qmass;
  logic [15:0]        tol, item;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req   <= in_data[2:0];
      addr  <= in_data[22:3];
      rbeg  <= in_data[43:23];
      rend  <= in_data[64:44];
      rid   <= in_data[80:65];
      qmass <= in_data[105:81];
      tol   <= in_data[121:106];
      item  <= in_data[137:122];
    end
  end

  logic [23:0] addr_ext;
  assign addr_ext = 24'(addr);

  // query window
  logic signed [25:0] m;
  logic signed [26:0] left, right;
  logic               skip_c;
  assign m     = (req == REQ_FRAG) ? (26'(qmass) + 26'(mass_shift)) : 26'(qmass);
  assign left  = 27'(m) - 27'(tol);
  assign right = 27'(m) + 27'(tol);
  assign skip_c = ((req == REQ_FRAG) && (item < start_item)) || right[26] ||
                  (right[25:0] >= 26'(column_count)) || (right[25:0] >= 26'(COL_LIM));

  logic [23:0] left_q, right_q;
  logic        skip;
  logic [14:0] amount;

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      left_q  <= left[26] ? '0 : left[23:0];
      right_q <= right[23:0];
      skip    <= ((req == REQ_FRAG) || (req == REQ_PREC)) && skip_c;
      amount  <= (req == REQ_FRAG) ? 15'd1 : precursor_score;
    end
  end

  // column range tables
  logic [20:0] cf_mem [COL_COUNT];
  logic [20:0] ce_mem [COL_COUNT];
  logic [20:0] cf_q, ce_q;
  logic        col_we;
  assign col_we = cmd.decode && (req == REQ_LOAD_COL) && (25'(addr_ext) < COL_LIM);

  always_ff @(posedge clk) begin
    if (col_we) begin
      cf_mem[addr_ext[CAW-1:0]] <= rbeg;
      ce_mem[addr_ext[CAW-1:0]] <= rend;
    end
    cf_q <= cf_mem[left_q[CAW-1:0]];
    ce_q <= ce_mem[right_q[CAW-1:0]];
  end

  // entry walk
  logic [20:0] j, e;
  logic [23:0] j_ext;
  logic [20:0] cnt;
  assign j_ext = 24'(j);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cnt <= '0;
    end else if (cmd.walk_start) begin
      j <= cf_q;
      e <= ce_q;
    end else if (cmd.rmw) begin
      j   <= j + 21'd1;
      cnt <= cnt + 21'd1;
    end else if (cmd.skip_entry) begin
      j <= j + 21'd1;
    end
  end

  // index entry table
  logic [15:0] er_mem [ENTRY_COUNT];
  logic [15:0] er_q;
  logic        ent_we;
  assign ent_we = cmd.decode && (req == REQ_LOAD_ENTRY) && (25'(addr_ext) < ENTRY_LIM);

  always_ff @(posedge clk) begin
    if (ent_we) er_mem[addr_ext[EAW-1:0]] <= rid;
    er_q <= er_mem[j_ext[EAW-1:0]];
  end

  logic [19:0] row_ext;
  assign row_ext = 20'(er_q);

  // score memory, single port
  logic [14:0]    sc_mem [ROW_COUNT];
  logic [14:0]    sc_q;
  logic [RAW-1:0] clr_cnt, sc_addr;
  logic [15:0]    sum;
  logic [14:0]    sc_wdata;
  logic           sc_we;

  assign sum = 16'(sc_q) + 16'(amount);
  always_comb begin
    if (cmd.clear_step) begin
      sc_addr  = clr_cnt;
      sc_wdata = '0;
      sc_we    = 1'b1;
    end else begin
      sc_addr  = (req == REQ_READ) ? addr[RAW-1:0] : row_ext[RAW-1:0];
      sc_wdata = sum[15] ? SCORE_MAX : sum[14:0];
      sc_we    = cmd.rmw;
    end
  end

  always_ff @(posedge clk) begin
    if (sc_we) sc_mem[sc_addr] <= sc_wdata;
    sc_q <= sc_mem[sc_addr];
  end

  // clearing counter
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_init) clr_cnt <= '0;
    else if (cmd.clear_step)   clr_cnt <= clr_cnt + 1'b1;
  end

  // result register
  logic [14:0] score_o;
  logic        read_ok;
  assign read_ok = (req == REQ_READ) && (21'(addr) < ROW_LIM);
  assign score_o = read_ok ? sc_q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_data <= {3'b0, skip, cnt, score_o};
  end

  // status
  assign st.req        = req;
  assign st.skip       = skip_c && ((req == REQ_FRAG) || (req == REQ_PREC));
  assign st.walk_more  = (j < e) && (25'(j) < ENTRY_LIM);
  assign st.row_ok     = 21'(er_q) < ROW_LIM;
  assign st.clear_last = (clr_cnt == ROW_LAST);
  assign st.out_busy   = out_valid && !out_ready;

endmodule

// File: design/mass_window_vote_scorer.sv
// mass_window_vote_scorer: inverted-index vote counter, top level
// loads and skipped queries pass from decode to the result register; a read
// waits on the score memory; a query reads the range tables, then for each entry
// checks the row and raises its score, stepping over unused rows; clear zeroes every
// row; one request at a time, the next transfer is taken from the cycle after the result register loads
// reset: synchronous, runs a clearing pass over all ROW_COUNT rows with s_tready low
`timescale 1ns / 1ps
module mass_window_vote_scorer #(
  parameter int COL_COUNT   = 1048576,
  parameter int ENTRY_COUNT = 1048576,
  parameter int ROW_COUNT   = 65536
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [24:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // req_type, table_address, range_begin, range_end_plus_one, row_id,
  // query_mass, mass_tolerance, item_index, zero fill
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // score_value, rows_raised, query_skipped, zero fill
  output logic [39:0]  m_tdata
);
  import mwvs_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic  idle;

  assign s_tready = idle;

  mwvs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_xfer (s_tvalid && idle),
    .idle    (idle),
    .st      (st),
    .cmd     (cmd)
  );

  mwvs_dpath #(
    .COL_COUNT   (COL_COUNT),
    .ENTRY_COUNT (ENTRY_COUNT),
    .ROW_COUNT   (ROW_COUNT)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

// File: design/mwvs_checker.sv
// mwvs_checker: port-level checks for the mass window vote scorer
// bound to mass_window_vote_scorer
`timescale 1ns / 1ps
module mwvs_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [39:0]  m_tdata
);

  // a held result stays valid
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // reset starts the clearing pass, no input taken
  a_clear: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input taken during clearing pass");

  // a skipped query raises nothing
  a_skip: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[36] |-> m_tdata[35:15] == 21'd0)
    else $error("skipped query reports raises");

  // a score read carries no query status
  a_read: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[14:0] != 15'd0 |-> m_tdata[36:15] == 22'd0)
    else $error("read result mixed with query status");

endmodule

bind mass_window_vote_scorer mwvs_checker u_mwvs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: tb/mass_window_vote_scorer_tb.sv
// mass_window_vote_scorer_tb: self-checking testbench for the mass window vote scorer
// drives request transfers, predicts every result with a local model of the index tables
// depends on mwvs_pkg and mass_window_vote_scorer
`timescale 1ns / 1ps
module mass_window_vote_scorer_tb;
  import mwvs_pkg::*;

  localparam int COLUMNS = 1048576;
  localparam int ENTRIES = 1048576;
  localparam int ROWS = 65536;
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int REPORT_LIMIT = 10;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int MAX_WALK = 2048;
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;
  // low and high regions that hold well-formed columns and entries
  localparam int LOW_COLS = 64;
  localparam int LOW_ENTRY_TOP = 264;
  localparam int HIGH_COL_BASE = COLUMNS - 64;
  localparam int HIGH_ENTRY_BASE = ENTRIES - 264;

  // request transfer layout, lowest field last
  typedef struct packed {
    logic [5:0]         pad;
    logic [15:0]        item;
    logic [15:0]        tol;
    logic signed [24:0] mass;
    logic [15:0]        rid;
    logic [20:0]        rend;
    logic [20:0]        rbeg;
    logic [19:0]        addr;
    logic [2:0]         req;
  } request_t;

  // result transfer layout
  typedef struct packed {
    logic [2:0]  pad;
    logic        skipped;
    logic [20:0] raised;
    logic [14:0] score;
  } tally_t;

  // directed row: an item with an optional typed answer, or a register setting
  typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_REGS} row_kind_t;
  typedef struct {
    row_kind_t kind;
    request_t  r;
    tally_t    answer;
  } row_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = CFG_COLUMN_COUNT;
  logic [24:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // req_type, table_address, range_begin, range_end_plus_one, row_id,
  // query_mass, mass_tolerance, item_index, zero fill
  logic [143:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // score_value, rows_raised, query_skipped, zero fill
  logic [39:0]  m_tdata;

  mass_window_vote_scorer i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // local copy of the block state
  int unsigned        column_limit;
  longint             fragment_shift;
  int unsigned        first_item;
  int unsigned        precursor_raise;
  int unsigned        col_first [int];
  int unsigned        col_end [int];
  logic [15:0]        entry_row [int];
  logic [14:0]        row_score [ROWS];

  row_t   rows [$];
  tally_t expected_tallies [$];
  int     fail_count = 0;
  int     mismatch_count = 0;
  int     sent_count = 0;
  int     query_count = 0;
  int     skip_count = 0;
  int     clear_count = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  int     hold_requests = 0;
  int     holds_served = 0;
  int     hold_left = 0;
  int     quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // append one row to the directed table
  function automatic void add_row(input row_kind_t kind, input request_t r,
                                  input tally_t answer);
    row_t n;
    n.kind = kind;
    n.r = r;
    n.answer = answer;
    rows.insert(rows.size(), n);
  endfunction

  // window bounds; returns 1 when the query is skipped
  function automatic bit window_bounds(input longint m, input int unsigned tol,
                                       output longint left, output longint right);
    left = m - tol;
    right = m + tol;
    if (left < 0) left = 0;
    return right < 0 || right >= column_limit || right >= COLUMNS;
  endfunction

  // true when a query is skipped or touches only written table entries and stays short
  function automatic bit window_defined(input longint m, input int unsigned tol);
    longint left, right;
    longint b, e;
    if (window_bounds(m, tol, left, right)) return 1'b1;
    if (!col_first.exists(int'(left)) || !col_end.exists(int'(right))) return 1'b0;
    b = col_first[int'(left)];
    e = col_end[int'(right)];
    if (e - b > MAX_WALK) return 1'b0;
    for (longint j = b; j < e && j < ENTRIES; j++)
      if (!entry_row.exists(int'(j))) return 1'b0;
    return 1'b1;
  endfunction

  // raise every row listed in the window
  function automatic tally_t raise_window(input longint m, input int unsigned tol,
                                          input int unsigned amount);
    tally_t t;
    longint left, right, b, e;
    int unsigned sum;
    logic [15:0] row;
    t = '0;
    if (window_bounds(m, tol, left, right)) begin
      t.skipped = 1'b1;
      return t;
    end
    b = col_first.exists(int'(left)) ? col_first[int'(left)] : 0;
    e = col_end.exists(int'(right)) ? col_end[int'(right)] : 0;
    for (longint j = b; j < e && j < ENTRIES; j++) begin
      row = entry_row.exists(int'(j)) ? entry_row[int'(j)] : 16'd0;
      sum = row_score[row] + amount;
      row_score[row] = (sum > SCORE_MAX) ? SCORE_MAX : sum[14:0];
      if (t.raised != 21'h1FFFFF) t.raised = t.raised + 1;
    end
    return t;
  endfunction

  // expected result of one request, updating the local state
  function automatic tally_t apply_request(input request_t r);
    tally_t t;
    t = '0;
    case (r.req)
      REQ_LOAD_COL: begin
        col_first[int'(r.addr)] = r.rbeg;
        col_end[int'(r.addr)] = r.rend;
      end
      REQ_LOAD_ENTRY: entry_row[int'(r.addr)] = r.rid;
      REQ_CLEAR: foreach (row_score[i]) row_score[i] = '0;
      REQ_FRAG: begin
        if (r.item < first_item) t.skipped = 1'b1;
        else t = raise_window(longint'(r.mass) + fragment_shift, r.tol, 1);
      end
      REQ_PREC: t = raise_window(longint'(r.mass), r.tol, precursor_raise);
      REQ_READ: if (r.addr < ROWS) t.score = row_score[r.addr[15:0]];
      default: ;
    endcase
    return t;
  endfunction

  // offer one request and record its expected tally once it is accepted
  task automatic send_request(input request_t r, input bit typed, input tally_t answer);
    tally_t t;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= r;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    t = apply_request(r);
    expected_tallies.insert(expected_tallies.size(), typed ? answer : t);
    sent_count++;
    if (r.req == REQ_FRAG || r.req == REQ_PREC) begin
      query_count++;
      if (t.skipped) skip_count++;
    end
    if (r.req == REQ_CLEAR) clear_count++;
  endtask

  // wait until every expected tally has arrived
  task automatic drain;
    s_tvalid <= 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write all four registers back to back while idle
  task automatic set_registers(input int unsigned cols, input longint shift,
                               input int unsigned first, input int unsigned raise);
    logic [24:0] shift_bits;
    shift_bits = shift[24:0];
    cfg_we <= 1'b1;
    cfg_index <= CFG_COLUMN_COUNT;
    cfg_data <= 25'(cols);
    @(posedge clk);
    cfg_index <= CFG_MASS_SHIFT;
    cfg_data <= shift_bits;
    @(posedge clk);
    cfg_index <= CFG_START_ITEM;
    cfg_data <= 25'(first);
    @(posedge clk);
    cfg_index <= CFG_PRECURSOR_SCORE;
    cfg_data <= 25'(raise);
    @(posedge clk);
    cfg_we <= 1'b0;
    column_limit = cols & 32'h1FFFFF;
    fragment_shift = longint'($signed(shift_bits));
    first_item = first & 32'hFFFF;
    precursor_raise = raise & 32'h7FFF;
  endtask

  function automatic request_t make_request(input logic [2:0] req, input int unsigned addr);
    request_t r;
    r = '0;
    r.req = req;
    r.addr = addr[19:0];
    return r;
  endfunction

  function automatic request_t make_query(input logic [2:0] req, input longint m,
                                          input int unsigned tol, input int unsigned item);
    request_t r;
    r = make_request(req, 0);
    r.mass = m[24:0];
    r.tol = tol[15:0];
    r.item = item[15:0];
    return r;
  endfunction

  function automatic request_t make_column(input int unsigned col, input int unsigned b,
                                           input int unsigned e);
    request_t r;
    r = make_request(REQ_LOAD_COL, col);
    r.rbeg = b[20:0];
    r.rend = e[20:0];
    return r;
  endfunction

  function automatic request_t make_entry(input int unsigned idx, input int unsigned row);
    request_t r;
    r = make_request(REQ_LOAD_ENTRY, idx);
    r.rid = row[15:0];
    return r;
  endfunction

  function automatic int unsigned pick_row();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 80) return $urandom_range(31);
    if (k < 88) return 65535;
    return $urandom_range(65535);
  endfunction

  // well-formed column range inside one of the written regions
  function automatic request_t sane_column(input bit high, input int unsigned slot);
    int unsigned b, e, top;
    top = high ? ENTRIES : LOW_ENTRY_TOP;
    b = (high ? HIGH_ENTRY_BASE : 0) + slot * 4 + $urandom_range(3);
    e = b + $urandom_range(6);
    if (e > top) e = top;
    return make_column((high ? HIGH_COL_BASE : 0) + slot, b, e);
  endfunction

  // random query aimed mostly at written columns, else a row read
  function automatic request_t random_query(input bit fragment);
    request_t r;
    longint target, m, shift;
    int unsigned tol, item, k;
    shift = fragment ? fragment_shift : 0;
    for (int attempt = 0; attempt < 20; attempt++) begin
      k = $urandom_range(99);
      if (k < 45) target = $urandom_range(70);
      else if (k < 88) target = COLUMNS - 1 - $urandom_range(70);
      else target = -longint'($urandom_range(40));
      k = $urandom_range(99);
      if (k < 65) tol = $urandom_range(3);
      else if (k < 93) tol = $urandom_range(12);
      else tol = $urandom_range(65535);
      m = target - shift;
      if ($urandom_range(99) < 10 || m < -(64'sd1 << 24) || m >= (64'sd1 << 24))
        m = longint'($signed(25'($urandom())));
      item = ($urandom_range(99) < 80) ? $urandom_range(65535, first_item)
                                       : $urandom_range(65535);
      r = make_query(fragment ? REQ_FRAG : REQ_PREC, m, tol, item);
      if (fragment && item < first_item) return r;
      if (window_defined(m + shift, tol)) return r;
    end
    return make_request(REQ_READ, pick_row());
  endfunction

  function automatic request_t random_request();
    request_t r;
    int unsigned k, b, e;
    k = $urandom_range(99);
    if (k < 40) return random_query(1'b0);
    if (k < 72) return random_query(1'b1);
    if (k < 84) begin
      k = $urandom_range(99);
      return make_request(REQ_READ, (k < 85) ? pick_row() : $urandom_range(1048575));
    end
    if (k < 92) begin
      if ($urandom_range(1)) return sane_column($urandom_range(1), $urandom_range(LOW_COLS - 1));
      if ($urandom_range(1)) return make_entry($urandom_range(LOW_ENTRY_TOP - 1), pick_row());
      return make_entry($urandom_range(ENTRIES - 1, HIGH_ENTRY_BASE), pick_row());
    end
    if (k < 98) begin
      // stray loads anywhere in the tables with wild ranges
      if ($urandom_range(1)) return make_entry($urandom_range(1048575), $urandom_range(65535));
      b = ($urandom_range(9) == 0) ? COLUMNS : $urandom_range(1048575);
      e = ($urandom_range(9) == 0) ? COLUMNS : $urandom_range(1048575);
      return make_column($urandom_range(1048575), b, e);
    end
    r = request_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    r.pad = '0;
    r.req = $urandom_range(1) ? REQ_SPARE_A : REQ_SPARE_B;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    tally_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_tallies.size() == 0) begin
        fail_count++;
        if (mismatch_count++ < REPORT_LIMIT)
          $display("unexpected result transfer %h", m_tdata);
      end else begin
        want = expected_tallies.pop_front();
        if (got.score !== want.score || got.raised !== want.raised ||
            got.skipped !== want.skipped || got.pad !== want.pad) begin
          fail_count++;
          if (mismatch_count++ < REPORT_LIMIT)
            $display("mismatch: score %0d/%0d raised %0d/%0d skipped %0d/%0d (exp/got)",
                     want.score, got.score, want.raised, got.raised,
                     want.skipped, got.skipped);
        end
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      m_tready <= 1'b0;
      hold_left <= 600;
      holds_served <= holds_served + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("mass_window_vote_scorer_tb NOT OK");
      $finish;
    end
  end

  initial begin
    row_t    row;
    tally_t  none;
    tally_t  hits3;
    tally_t  skip;
    request_t regs;
    int      phase_idle [5];
    int      phase_stall [5];

    none = '0;
    hits3 = '0;
    hits3.raised = 3;
    skip = '0;
    skip.skipped = 1'b1;
    column_limit = COLUMNS;
    fragment_shift = 0;
    first_item = 0;
    precursor_raise = 1;
    foreach (row_score[i]) row_score[i] = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // populate both column regions and their entries
    for (int c = 0; c < LOW_COLS; c++) send_request(sane_column(1'b0, c), 1'b0, none);
    for (int c = 0; c < LOW_COLS; c++) send_request(sane_column(1'b1, c), 1'b0, none);
    for (int j = 0; j < LOW_ENTRY_TOP; j++) send_request(make_entry(j, pick_row()), 1'b0, none);
    for (int j = HIGH_ENTRY_BASE; j < ENTRIES; j++)
      send_request(make_entry(j, pick_row()), 1'b0, none);

    // directed table; register rows carry column count in rbeg, shift in mass,
    // first item in item and precursor raise in rid
    add_row(ROW_TYPED, make_request(REQ_READ, 0), none);
    add_row(ROW_TYPED, make_request(REQ_READ, 65535), none);
    add_row(ROW_TYPED, make_request(REQ_READ, 1048575), none);
    add_row(ROW_TYPED, make_request(REQ_SPARE_A, 0), none);
    regs = request_t'({144{1'b1}});
    regs.pad = '0;
    regs.req = REQ_SPARE_B;
    add_row(ROW_TYPED, regs, none);
    add_row(ROW_TYPED, make_column(0, 0, 3), none);
    add_row(ROW_TYPED, make_entry(0, 9), none);
    add_row(ROW_TYPED, make_entry(1, 65535), none);
    add_row(ROW_TYPED, make_entry(2, 9), none);
    add_row(ROW_TYPED, make_query(REQ_PREC, 0, 0, 0), hits3);
    add_row(ROW_TYPED, make_query(REQ_FRAG, 0, 0, 65535), hits3);
    add_row(ROW_ITEM, make_request(REQ_READ, 9), none);
    // windows out of range
    add_row(ROW_TYPED, make_query(REQ_PREC, -1, 0, 0), skip);
    add_row(ROW_TYPED, make_query(REQ_PREC, -16777216, 65535, 0), skip);
    add_row(ROW_TYPED, make_query(REQ_PREC, 16777215, 65535, 0), skip);
    add_row(ROW_TYPED, make_query(REQ_PREC, COLUMNS, 0, 0), skip);
    // top column and a clamped left edge
    add_row(ROW_TYPED, make_column(COLUMNS - 1, COLUMNS - 3, COLUMNS), none);
    add_row(ROW_ITEM, make_query(REQ_PREC, COLUMNS - 1, 0, 0), none);
    add_row(ROW_ITEM, make_query(REQ_PREC, 1, 5, 0), none);
    // inverted entry range raises nothing
    add_row(ROW_TYPED, make_column(5, 9, 2), none);
    add_row(ROW_TYPED, make_query(REQ_PREC, 5, 0, 0), none);
    // early fragment item and saturation
    regs = make_request(REQ_READ, 0);
    regs.rbeg = COLUMNS;
    regs.item = 5;
    regs.rid = 16'd32767;
    add_row(ROW_REGS, regs, none);
    add_row(ROW_TYPED, make_query(REQ_FRAG, 0, 0, 4), skip);
    add_row(ROW_TYPED, make_query(REQ_PREC, 0, 0, 0), hits3);
    row = '{ROW_TYPED, make_request(REQ_READ, 9), none};
    row.answer.score = SCORE_MAX;
    add_row(row.kind, row.r, row.answer);
    add_row(ROW_TYPED, make_request(REQ_CLEAR, 0), none);
    add_row(ROW_TYPED, make_request(REQ_READ, 9), none);
    regs.item = 0;
    regs.rid = 16'd1;
    add_row(ROW_REGS, regs, none);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REGS) begin
        drain();
        set_registers(rows[i].r.rbeg, longint'(rows[i].r.mass), rows[i].r.item, rows[i].r.rid);
      end else begin
        send_request(rows[i].r, rows[i].kind == ROW_TYPED, rows[i].answer);
      end
    end
    // restore the well-formed column 5
    send_request(sane_column(1'b0, 5), 1'b0, none);

    // random phases with different register settings and idling
    phase_idle = '{0, 59, 0, 35, 0};
    phase_stall = '{0, 0, 59, 35, 0};
    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        1: set_registers(100, -3, 10, 32767);
        2: set_registers(1, 16777215, 65535, 0);
        3: set_registers(COLUMNS - 1, -16777216, 1, 5);
        4: set_registers(COLUMNS, 7, 0, 1000);
        default: set_registers(COLUMNS, 0, 0, 1);
      endcase
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      if (p == 1 || p == 3) send_request(make_request(REQ_CLEAR, 0), 1'b0, none);
      if (p == 4) hold_requests++;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(random_request(), 1'b0, none);
    end

    drain();
    repeat (40) @(posedge clk);
    fail_count += expected_tallies.size();
    $display("sent %0d requests: %0d queries (%0d skipped), %0d score clears",
             sent_count, query_count, skip_count, clear_count);
    $display("five register settings, idle and stall mixes, one long output hold-off");
    if (fail_count == 0) begin
      $display("mass_window_vote_scorer_tb OK");
    end else begin
      $display("mass_window_vote_scorer_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
design/mwvs_pkg.sv
design/mwvs_ctrl.sv
design/mwvs_dpath.sv
design/mass_window_vote_scorer.sv
design/mwvs_checker.sv
tb/mass_window_vote_scorer_tb.sv
